>>> hw/rtl/dual_moving_median_sum_top_defines.svh
// Assertion macros for the dual moving median sum block
`ifndef DUAL_MOVING_MEDIAN_SUM_TOP_DEFINES_SVH
`define DUAL_MOVING_MEDIAN_SUM_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, idle while arst_n is low
`define DMMS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, idle while arst_n is low
`define DMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/dmms_pkg.sv
// Shared constants, codes and types for the dual moving median sum block
package dmms_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int SAMPLE_WIDTH  = 32;
	localparam int SUM_WIDTH     = SAMPLE_WIDTH + 1;
	localparam int IDX_W         = $clog2(HISTORY_DEPTH);
	localparam int RANK_W        = $clog2(HISTORY_DEPTH + 1);

	localparam logic [RANK_W-1:0] MEDIAN_RANK = RANK_W'(HISTORY_DEPTH / 2);
	localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(HISTORY_DEPTH - 1);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic             wr_en;
		logic             clr;
		logic             adv;
		logic [IDX_W-1:0] wr_idx;
	} lane_ctrl_t;

endpackage

>>> hw/rtl/dmms_in_if.sv
// Input channel: opcode and one sample per load-cell channel
interface dmms_in_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       opcode;
	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0]   first_sample;
	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0]   second_sample;

	modport source (output valid, output opcode, output first_sample,
		output second_sample, input ready);
	modport sink (input valid, input opcode, input first_sample,
		input second_sample, output ready);
	modport mon (input valid, input ready, input opcode, input first_sample,
		input second_sample);
endinterface

>>> hw/rtl/dmms_out_if.sv
// Output channel: summed median weight
interface dmms_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [dmms_pkg::SUM_WIDTH-1:0]    total_weight;

	modport source (output valid, output total_weight, input ready);
	modport sink (input valid, input total_weight, output ready);
	modport mon (input valid, input ready, input total_weight);
endinterface

>>> hw/rtl/dmms_lane.sv
// One channel: sample ring and rank-based median selection
module dmms_lane (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dmms_pkg::lane_ctrl_t                     ctrl,
	input  logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] median_s1
);

	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] ring_q [dmms_pkg::HISTORY_DEPTH];
	logic        [dmms_pkg::HISTORY_DEPTH-1:0] pick;
	logic        [dmms_pkg::RANK_W-1:0]        rank;
	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] median_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dmms_pkg::HISTORY_DEPTH; i++) ring_q[i] <= '0;
		end else if (ctrl.clr) begin
			for (int i = 0; i < dmms_pkg::HISTORY_DEPTH; i++) ring_q[i] <= '0;
		end else if (ctrl.wr_en) begin
			ring_q[ctrl.wr_idx] <= sample;
		end
	end

	// Rank each entry against all others; ties break by ring position
	always_comb begin
		pick = '0;
		rank = '0;
		for (int i = 0; i < dmms_pkg::HISTORY_DEPTH; i++) begin
			rank = '0;
			for (int j = 0; j < dmms_pkg::HISTORY_DEPTH; j++) begin
				if ((ring_q[j] < ring_q[i]) || ((ring_q[j] == ring_q[i]) && (j < i))) begin
					rank = rank + dmms_pkg::RANK_W'(1);
				end
			end
			pick[i] = (rank == dmms_pkg::MEDIAN_RANK);
		end
	end

	// Exactly one entry holds the median rank
	always_comb begin
		median_d = '0;
		for (int i = 0; i < dmms_pkg::HISTORY_DEPTH; i++) begin
			if (pick[i]) begin
				median_d = median_d | ring_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			median_s1 <= median_d;
		end
	end

endmodule

>>> hw/rtl/dmms_merge.sv
// Merge: add the two lane medians into the output register
module dmms_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     valid_s1,
	input  logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] first_median_s1,
	input  logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] second_median_s1,
	output logic                                     adv,
	dmms_out_if.source                               result
);

	logic                                    out_valid_q;
	logic signed [dmms_pkg::SUM_WIDTH-1:0]   total_q;

	assign adv = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			total_q <= dmms_pkg::SUM_WIDTH'(first_median_s1)
				+ dmms_pkg::SUM_WIDTH'(second_median_s1);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.total_weight = total_q;

endmodule

>>> hw/rtl/dual_moving_median_sum_top.sv
// Top level: two median lanes, shared ring index and summing output stage
// Sample beats go into the rings; medians, then their sum, are registered.
// Throughput: one beat per cycle while the result side keeps taking beats;
// the whole pipe stalls only while a finished result waits to be taken.
// A clear beat yields no result.
// Reset (arst_n low) zeroes both rings and the index and empties the pipe.
module dual_moving_median_sum_top (
	input  logic       clk,
	input  logic       arst_n,
	dmms_in_if.sink    samples,
	dmms_out_if.source result
);

	// Pipe advance: set by the output stage, low only while a result is stalled
	logic                                     adv;
	logic                                     acc;
	logic [dmms_pkg::IDX_W-1:0]               idx_q;
	logic                                     pend_q;
	logic                                     valid_s1;
	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] first_median_s1;
	logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] second_median_s1;
	dmms_pkg::lane_ctrl_t                     ctrl;

	// Take a beat whenever the pipe can move
	assign samples.ready = adv;
	assign acc           = samples.valid && adv;

	assign ctrl.wr_en  = acc && (samples.opcode == dmms_pkg::OP_SAMPLE);
	assign ctrl.clr    = acc && (samples.opcode == dmms_pkg::OP_CLEAR);
	assign ctrl.adv    = adv;
	assign ctrl.wr_idx = idx_q;

	// Shared ring index: drop to zero on clear, wrap after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.clr) begin
			idx_q <= '0;
		end else if (ctrl.wr_en) begin
			idx_q <= (idx_q == dmms_pkg::LAST_IDX) ? '0 : idx_q + dmms_pkg::IDX_W'(1);
		end
	end

	// pend_q marks rings that hold a freshly written pair whose median is
	// still to be taken; the lanes read the rings while the next beat is
	// written, so the median register captures the state before that write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			pend_q   <= ctrl.wr_en;
			valid_s1 <= pend_q;
		end
	end

	dmms_lane u_lane_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample    (samples.first_sample),
		.median_s1 (first_median_s1)
	);

	dmms_lane u_lane_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample    (samples.second_sample),
		.median_s1 (second_median_s1)
	);

	// Sum the lane medians and hold the result until taken
	dmms_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s1         (valid_s1),
		.first_median_s1  (first_median_s1),
		.second_median_s1 (second_median_s1),
		.adv              (adv),
		.result           (result)
	);

endmodule

>>> hw/rtl/dmms_checker.sv
// Port-level assertions for the dual moving median sum block, with bind
`include "dual_moving_median_sum_top_defines.svh"

module dmms_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_ready,
	input logic                                     in_opcode,
	input logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] in_first,
	input logic signed [dmms_pkg::SAMPLE_WIDTH-1:0] in_second,
	input logic                                     out_valid,
	input logic                                     out_ready,
	input logic signed [dmms_pkg::SUM_WIDTH-1:0]    out_total
);

	logic smp_beat;
	logic clr_beat;
	logic zero_beat;
	logic out_stall;
	logic zero_out;

	assign smp_beat  = in_valid && in_ready && (in_opcode == dmms_pkg::OP_SAMPLE);
	assign clr_beat  = in_valid && in_ready && (in_opcode == dmms_pkg::OP_CLEAR);
	assign zero_beat = smp_beat && (in_first == '0) && (in_second == '0);
	assign out_stall = out_valid && !out_ready;
	assign zero_out  = out_valid && (out_total == '0);

	// A sample beat followed by out_ready, then out_ready again
	sequence s_smp_taken;
		smp_beat ##1 out_ready ##1 out_ready;
	endsequence

	// A clear, then an all-zero pair, then out_ready, then out_ready again
	sequence s_clr_zero;
		clr_beat ##1 zero_beat ##1 out_ready ##1 out_ready;
	endsequence

	// Hold a stalled result beat unchanged
	`DMMS_ASSERT_NEXT(a_result_hold, out_stall, out_valid && $stable(out_total), "stalled beat changed")

	// Refuse input only while a result is stalled
	`DMMS_ASSERT(a_ready_only_stall, !in_ready, out_stall, "input refused without output stall")

	// A sample beat followed by out_ready, then out_ready again, shows a result
	`DMMS_ASSERT_NEXT(a_sample_result, s_smp_taken, out_valid, "sample beat gave no result")

	// After a clear, an all-zero pair sums to zero
	`DMMS_ASSERT_NEXT(a_clear_zero, s_clr_zero, zero_out, "zero pair after clear not zero")

endmodule

bind dual_moving_median_sum_top dmms_checker u_dmms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_opcode (samples.opcode),
	.in_first  (samples.first_sample),
	.in_second (samples.second_sample),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_total (result.total_weight)
);
